// ===== src/slbm_pkg.sv =====
// types and constants shared by the spectrum led bar mapper
// no dependencies
package slbm_pkg;

    localparam int LED_DEPTH  = 64;
    localparam int LED_W      = 6;
    localparam int COUNT_W    = 7;
    localparam int EDGE_W     = 10;
    localparam int MAG_W      = 16;
    localparam int RGB_W      = 24;
    localparam int LEVEL_W    = 10;
    localparam int SQ_X_W     = 36;
    localparam int ROOT_W     = SQ_X_W / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = LEVEL_W;
    localparam int CNT_W      = 5;

    localparam logic [LEVEL_W-1:0] FULL_SCALE  = 10'd1000;
    localparam logic [19:0]        SQ_SCALE    = 20'd1000000;
    localparam logic [15:0]        RECIP_K     = 16'd33555;
    localparam logic [COUNT_W-1:0] LED_MAX     = 7'd64;
    localparam logic [EDGE_W-1:0]  BIN_START   = 10'd1;

    localparam logic [COUNT_W-1:0] LED_COUNT_RST = 7'd10;
    localparam logic [RGB_W-1:0]   MIN_COLOR_RST = 24'h000000;
    localparam logic [RGB_W-1:0]   MAX_COLOR_RST = 24'hFFFFFF;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_LED_COUNT = 2'd0,
        CFG_MIN_COLOR = 2'd1,
        CFG_MAX_COLOR = 2'd2,
        CFG_LIQUID    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SQRT,
        S_PEAK,
        S_DIV,
        S_LERP_A,
        S_LERP_B,
        S_OUT
    } state_t;

    typedef struct packed {
        logic       in_ready;
        logic       sqrt_load;
        logic       sqrt_step;
        logic       peak;
        logic       div_step;
        logic       lerp_a;
        logic       lerp_b;
        logic [1:0] chan;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_mode;
        logic bin_active;
        logic close;
        logic need_div;
        logic out_free;
    } status_t;

endpackage

// ===== src/slbm_if.sv =====
// valid/ready channel interfaces for bin items and colour results
// uses slbm_pkg widths
interface slbm_in_if;
    import slbm_pkg::*;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [LED_W-1:0]   led_index;
    logic [EDGE_W-1:0]  bucket_edge;
    logic               led_enable;
    logic [EDGE_W-1:0]  bin_index;
    logic [MAG_W-1:0]   magnitude;
    logic [RGB_W-1:0]   tint;
    modport source (output valid, mode, led_index, bucket_edge, led_enable, bin_index,
                    magnitude, tint, input ready);
    modport sink (input valid, mode, led_index, bucket_edge, led_enable, bin_index,
                  magnitude, tint, output ready);
endinterface

interface slbm_out_if;
    import slbm_pkg::*;
    logic              valid;
    logic              ready;
    logic [LED_W-1:0]  led_number;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              lit;
    logic              color_changed;
    logic              last;
    modport source (output valid, led_number, red, green, blue, lit, color_changed, last,
                    input ready);
    modport sink (input valid, led_number, red, green, blue, lit, color_changed, last,
                  output ready);
endinterface

// ===== src/spectrum_led_bar_mapper.sv =====
// spectrum led bar mapper: frames of bin magnitudes to per-led colours
// Channels: in_ch takes table writes (mode 0) and bins (mode 1), one beat at a time;
// out_ch gives one colour beat for each led whose bucket closes.
// Config: cfg_we/cfg_index/cfg_data write led_count, min_color, max_color,
// liquid_mode; write only while idle. A led_count write clears peaks and colours.
// Flow: a table write, or a bin that is outside the active leds, is taken in idle;
// a bin inside an active frame also passes the table read and edge check.
// A bin that closes a led goes through: accept, table read, edge check, an
// 18-step bit-pair square root, peak update, a 10-step restoring divide when the
// level is rescaled, a lerp (LERP_A then LERP_B) per colour channel and the output
// load, which waits until the output register is free.
// A finished colour waits in the output register; the next bin is accepted
// meanwhile, and only a further closing led waits for the register to empty.
// Reset: led_count 10, colours black to white, peaks and stored colours cleared,
// frame counter zero. Led table entries hold nothing until written.
module spectrum_led_bar_mapper (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [slbm_pkg::RGB_W-1:0] cfg_data,
    slbm_in_if.sink                    in_ch,
    slbm_out_if.source                 out_ch
);
    import slbm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    slbm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // datapath
    slbm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef NO_ASSERTIONS
    // a result is only loaded when the output register is free
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("result loaded over a waiting beat");

    // a new output beat appears only after a finish command
    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(cmd.finish))
        else $error("output valid without finish");

    // a dark led reports no colour and no change
    a_dark_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.lit) |-> (out_ch.red == 8'd0 && out_ch.green == 8'd0
            && out_ch.blue == 8'd0 && !out_ch.color_changed))
        else $error("disabled led with colour");

    // no input accepted while an item is in work
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sqrt_step || cmd.div_step || cmd.lerp_a) |-> !in_ch.ready)
        else $error("input ready during computation");
`endif

endmodule

// ===== src/slbm_ctrl.sv =====
// sequencer for the led bar mapper: bin handling, sqrt, divide, lerp steps
// depends on slbm_pkg
module slbm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  slbm_pkg::status_t status,
    output slbm_pkg::cmd_t    cmd
);
    import slbm_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        chan_reg, chan_next;

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            chan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            chan_reg  <= chan_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        chan_next  = chan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (status.in_valid && status.in_mode && status.bin_active)
                    state_next = S_READ;
            end
            S_READ:
                state_next = S_CHECK;
            S_CHECK:
            begin
                cnt_next   = '0;
                state_next = status.close ? S_SQRT : S_IDLE;
            end
            S_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    state_next = S_PEAK;
            end
            S_PEAK:
            begin
                cnt_next   = '0;
                chan_next  = '0;
                state_next = status.need_div ? S_DIV : S_LERP_A;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = S_LERP_A;
            end
            S_LERP_A:
                state_next = S_LERP_B;
            S_LERP_B:
            begin
                if (chan_reg == 2'd2)
                    state_next = S_OUT;
                else
                begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = S_LERP_A;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd           = '0;
        cmd.chan      = chan_reg;
        unique case (state_reg)
            S_IDLE:   cmd.in_ready  = 1'b1;
            S_READ:   ;
            S_CHECK:  cmd.sqrt_load = status.close;
            S_SQRT:   cmd.sqrt_step = 1'b1;
            S_PEAK:   cmd.peak      = 1'b1;
            S_DIV:    cmd.div_step  = 1'b1;
            S_LERP_A: cmd.lerp_a    = 1'b1;
            S_LERP_B: cmd.lerp_b    = 1'b1;
            S_OUT:    cmd.finish    = status.out_free;
            default:  ;
        endcase
    end

endmodule

// ===== src/slbm_dp.sv =====
// datapath: config registers, led tables, sqrt and divide units, lerp, output register
// depends on slbm_pkg and slbm_if
module slbm_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [slbm_pkg::RGB_W-1:0] cfg_data,
    slbm_in_if.sink                    in_ch,
    slbm_out_if.source                 out_ch,
    input  slbm_pkg::cmd_t             cmd,
    output slbm_pkg::status_t          status
);
    import slbm_pkg::*;

    // configuration
    logic [COUNT_W-1:0] led_count_reg;
    logic [RGB_W-1:0]   min_color_reg, max_color_reg;
    logic               liquid_reg;

    // frame state
    logic [COUNT_W-1:0] cur_reg;
    logic [MAG_W-1:0]   bm_reg;
    logic [EDGE_W-1:0]  pe_reg;
    logic [2:0]         fm5_reg;
    logic [RGB_W-1:0]   tint_reg;

    // per item working registers
    logic [LED_W-1:0]   led_reg;
    logic [EDGE_W-1:0]  bin_reg;
    logic [EDGE_W-1:0]  edge_reg;
    logic [SQ_X_W-1:0]  x_reg;
    logic [ROOT_W:0]    rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [LEVEL_W-1:0] peak_reg;
    logic [LEVEL_W-1:0] q_reg;
    logic [LEVEL_W-1:0] drem_reg;
    logic [LEVEL_W-1:0] nlo_reg;
    logic [17:0]        lnum_reg;
    logic [7:0]         r_reg, g_reg, b_reg;

    // memories and valid bits
    logic [EDGE_W:0]      edge_mem [LED_DEPTH];
    logic [LEVEL_W-1:0]   peak_mem [LED_DEPTH];
    logic [RGB_W-1:0]     col_mem  [LED_DEPTH];
    logic [EDGE_W:0]      edge_rd_reg;
    logic [LEVEL_W-1:0]   peak_rd_reg;
    logic [RGB_W-1:0]     col_rd_reg;
    logic [LED_DEPTH-1:0] pk_valid_reg;
    logic [LED_DEPTH-1:0] col_valid_reg;

    // output register
    logic               ov_reg;
    logic [LED_W-1:0]   o_led_reg;
    logic [RGB_W-1:0]   o_rgb_reg;
    logic               o_lit_reg, o_chg_reg, o_last_reg;

    logic               beat, wr_beat, bin_beat, bin_start, active;
    logic [COUNT_W-1:0] n_leds, cur_eff;
    logic [MAG_W-1:0]   bm_eff;
    logic [LED_W-1:0]   rd_addr;
    logic [EDGE_W:0]    edge_eff;
    logic [ROOT_W+2:0]  sq_rem, sq_trial;
    logic [LEVEL_W-1:0] lvl, p0, p1, p2;
    logic [19:0]        lvl_num;
    logic [LEVEL_W:0]   div_t;
    logic [7:0]         from_c, to_c;
    logic signed [9:0]  diff;
    logic signed [21:0] lsum;
    logic [30:0]        lprod;
    logic [RGB_W-1:0]   rgb, from_rgb, to_rgb;
    logic               lit;

    // handshake and frame bookkeeping
    assign beat      = in_ch.valid && cmd.in_ready;
    assign wr_beat   = beat && !in_ch.mode;
    assign bin_beat  = beat && in_ch.mode;
    assign bin_start = in_ch.bin_index == BIN_START;
    assign n_leds    = (led_count_reg > LED_MAX) ? LED_MAX : led_count_reg;
    assign cur_eff   = bin_start ? '0 : cur_reg;
    assign bm_eff    = bin_start ? '0 : bm_reg;
    assign active    = cur_eff < n_leds;
    assign rd_addr   = cur_eff[LED_W-1:0];
    assign in_ch.ready = cmd.in_ready;

    // edge raised above previous end
    assign edge_eff = (edge_rd_reg[EDGE_W-1:0] <= pe_reg) ? ({1'b0, pe_reg} + 1'b1)
                                                          : {1'b0, edge_rd_reg[EDGE_W-1:0]};

    // sqrt digit step
    assign sq_rem   = {rem_reg, x_reg[SQ_X_W-1 -: 2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};

    // level, peak decay and hold
    assign lvl     = (root_reg[ROOT_W-1:8] < 10'd4) ? '0 : root_reg[ROOT_W-1:8] - 10'd4;
    assign p0      = pk_valid_reg[led_reg] ? peak_rd_reg : '0;
    assign p1      = (fm5_reg == 3'd0 && p0 != '0) ? p0 - 1'b1 : p0;
    assign p2      = (lvl > p1) ? lvl : p1;
    assign lvl_num = 20'(lvl) * 20'(FULL_SCALE);

    // divide step
    assign div_t = {drem_reg, nlo_reg[LEVEL_W-1]};

    // lerp channel select
    assign from_rgb = liquid_reg ? '0 : min_color_reg;
    assign to_rgb   = liquid_reg ? tint_reg : max_color_reg;
    always_comb
    begin
        case (cmd.chan)
            2'd0:    begin from_c = from_rgb[23:16]; to_c = to_rgb[23:16]; end
            2'd1:    begin from_c = from_rgb[15:8];  to_c = to_rgb[15:8];  end
            default: begin from_c = from_rgb[7:0];   to_c = to_rgb[7:0];   end
        endcase
    end
    assign diff  = signed'({2'b00, to_c}) - signed'({2'b00, from_c});
    assign lsum  = signed'({4'b0, 18'(from_c) * 18'(FULL_SCALE)})
                 + 22'(diff * signed'({1'b0, q_reg}));
    assign lprod = 31'(lnum_reg[17:3]) * 31'(RECIP_K);

    assign rgb = {r_reg, g_reg, b_reg};
    assign lit = edge_rd_reg[EDGE_W];

    // status
    assign status.in_valid   = in_ch.valid;
    assign status.in_mode    = in_ch.mode;
    assign status.bin_active = active;
    assign status.close      = {1'b0, bin_reg} >= edge_eff;
    assign status.need_div   = (p2 > 10'd5) && (lvl < p2 - 10'd5);
    assign status.out_free   = !ov_reg || out_ch.ready;

    // edge and enable memory
    always_ff @(posedge clk)
    begin
        if (wr_beat)
            edge_mem[in_ch.led_index] <= {in_ch.led_enable, in_ch.bucket_edge};
        if (bin_beat)
            edge_rd_reg <= edge_mem[rd_addr];
    end

    // peak memory
    always_ff @(posedge clk)
    begin
        if (cmd.peak)
            peak_mem[led_reg] <= p2;
        if (bin_beat)
            peak_rd_reg <= peak_mem[rd_addr];
    end

    // colour memory
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            col_mem[led_reg] <= lit ? rgb : '0;
        if (bin_beat)
            col_rd_reg <= col_mem[rd_addr];
    end

    // control state: config, frame, valid bits, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= LED_COUNT_RST;
            min_color_reg <= MIN_COLOR_RST;
            max_color_reg <= MAX_COLOR_RST;
            liquid_reg    <= 1'b0;
            cur_reg       <= '0;
            bm_reg        <= '0;
            pe_reg        <= '0;
            fm5_reg       <= '0;
            tint_reg      <= '0;
            pk_valid_reg  <= '0;
            col_valid_reg <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LED_COUNT:
                    begin
                        led_count_reg <= cfg_data[COUNT_W-1:0];
                        pk_valid_reg  <= '0;
                        col_valid_reg <= '0;
                    end
                    CFG_MIN_COLOR: min_color_reg <= cfg_data;
                    CFG_MAX_COLOR: max_color_reg <= cfg_data;
                    default:       liquid_reg    <= cfg_data[0];
                endcase
            end
            if (bin_beat)
            begin
                if (bin_start)
                begin
                    fm5_reg  <= (fm5_reg == 3'd4) ? 3'd0 : fm5_reg + 1'b1;
                    tint_reg <= in_ch.tint;
                    cur_reg  <= '0;
                    pe_reg   <= '0;
                    bm_reg   <= '0;
                end
                if (active)
                    bm_reg <= (in_ch.magnitude > bm_eff) ? in_ch.magnitude : bm_eff;
            end
            if (cmd.peak)
                pk_valid_reg[led_reg] <= 1'b1;
            if (cmd.finish)
            begin
                col_valid_reg[led_reg] <= lit;
                cur_reg <= {1'b0, led_reg} + 1'b1;
                bm_reg  <= '0;
                pe_reg  <= edge_reg;
                ov_reg  <= 1'b1;
            end
            else if (out_ch.ready)
                ov_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (bin_beat)
        begin
            led_reg <= rd_addr;
            bin_reg <= in_ch.bin_index;
        end
        if (cmd.sqrt_load)
        begin
            edge_reg <= edge_eff[EDGE_W-1:0];
            x_reg    <= SQ_X_W'(bm_reg) * SQ_X_W'(SQ_SCALE);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step)
        begin
            x_reg <= x_reg << 2;
            if (sq_rem >= sq_trial)
            begin
                rem_reg  <= (ROOT_W+1)'(sq_rem - sq_trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= (ROOT_W+1)'(sq_rem);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.peak)
        begin
            peak_reg <= p2;
            q_reg    <= lvl;
            drem_reg <= lvl_num[19:10];
            nlo_reg  <= lvl_num[9:0];
        end
        if (cmd.div_step)
        begin
            nlo_reg <= nlo_reg << 1;
            if (div_t >= {1'b0, peak_reg})
            begin
                drem_reg <= LEVEL_W'(div_t - {1'b0, peak_reg});
                q_reg    <= {q_reg[LEVEL_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= div_t[LEVEL_W-1:0];
                q_reg    <= {q_reg[LEVEL_W-2:0], 1'b0};
            end
        end
        if (cmd.lerp_a)
            lnum_reg <= lsum[17:0];
        if (cmd.lerp_b)
        begin
            case (cmd.chan)
                2'd0:    r_reg <= lprod[29:22];
                2'd1:    g_reg <= lprod[29:22];
                default: b_reg <= lprod[29:22];
            endcase
        end
        if (cmd.finish)
        begin
            o_led_reg  <= led_reg;
            o_rgb_reg  <= lit ? rgb : '0;
            o_lit_reg  <= lit;
            o_chg_reg  <= lit && (!col_valid_reg[led_reg] || col_rd_reg != rgb);
            o_last_reg <= ({1'b0, led_reg} + 1'b1) == n_leds;
        end
    end

    assign out_ch.valid         = ov_reg;
    assign out_ch.led_number    = o_led_reg;
    assign out_ch.red           = o_rgb_reg[23:16];
    assign out_ch.green         = o_rgb_reg[15:8];
    assign out_ch.blue          = o_rgb_reg[7:0];
    assign out_ch.lit           = o_lit_reg;
    assign out_ch.color_changed = o_chg_reg;
    assign out_ch.last          = o_last_reg;

endmodule
